/* design/kdlp_pkg.sv */
package kdlp_pkg;

	localparam int NUM_KEYS_DEF = 6;
	localparam int IN_KEYS      = 6;
	localparam int TIMER_W      = 11;
	localparam int CFG_W        = 10;
	localparam int CFG_IDX_W    = 2;

	localparam logic [CFG_W-1:0] DEBOUNCE_RST = 10'd10;
	localparam logic [CFG_W-1:0] LONG_RST     = 10'd100;

	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 2'd1;

	typedef enum logic [2:0] {
		ST_IDLE              = 3'd0,
		ST_DEBOUNCE          = 3'd1,
		ST_PRESS_EDGE        = 3'd2,
		ST_PRESSED           = 3'd3,
		ST_LONG              = 3'd4,
		ST_RELEASE_EDGE      = 3'd5,
		ST_LONG_RELEASE_EDGE = 3'd6
	} key_state_t;

	typedef struct packed {
		logic [7:0]         elapsed_ms;
		logic [IN_KEYS-1:0] key_levels;
	} item_t;

	typedef struct packed {
		logic [2:0]         front_state;
		logic [2:0]         back_state;
		logic [2:0]         left_state;
		logic [2:0]         right_state;
		logic [2:0]         middle_state;
		logic [2:0]         extra_state;
		logic [IN_KEYS-1:0] sampled_levels;
	} result_t;

	typedef struct packed {
		logic [CFG_W-1:0] debounce_ms;
		logic [CFG_W-1:0] long_press_ms;
	} cfg_t;

endpackage

/* design/kdlp_key.sv */
module kdlp_key
	import kdlp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  logic       down,
	input  logic [7:0] elapsed_ms,
	input  cfg_t       cfg,
	output key_state_t state
);

	key_state_t         state_q, state_d;
	logic [TIMER_W-1:0] timer_q, timer_d;
	logic [TIMER_W:0]   sum;
	logic [TIMER_W-1:0] timer_sat;

	// saturate the accumulated hold time
	assign sum       = {1'b0, timer_q} + {{(TIMER_W-7){1'b0}}, elapsed_ms};
	assign timer_sat = sum[TIMER_W] ? {TIMER_W{1'b1}} : sum[TIMER_W-1:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (down)
					state_d = ST_DEBOUNCE;
			end
			ST_DEBOUNCE: begin
				if (!down)
					state_d = ST_IDLE;
				else if (timer_sat > {1'b0, cfg.debounce_ms})
					state_d = ST_PRESS_EDGE;
			end
			ST_PRESS_EDGE: begin
				state_d = down ? ST_PRESSED : ST_IDLE;
			end
			ST_PRESSED: begin
				if (!down)
					state_d = ST_RELEASE_EDGE;
				else if (timer_sat > {1'b0, cfg.long_press_ms})
					state_d = ST_LONG;
			end
			ST_LONG: begin
				if (!down)
					state_d = ST_LONG_RELEASE_EDGE;
			end
			ST_RELEASE_EDGE, ST_LONG_RELEASE_EDGE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = state_q;
			end
		endcase
	end

	always_comb begin
		timer_d = timer_q;
		unique case (state_q)
			ST_IDLE: begin
				if (down)
					timer_d = '0;
			end
			ST_DEBOUNCE: begin
				if (!down || timer_sat > {1'b0, cfg.debounce_ms})
					timer_d = '0;
				else
					timer_d = timer_sat;
			end
			ST_PRESS_EDGE: begin
				// a release right at the edge keeps the timer
				if (down)
					timer_d = '0;
			end
			ST_PRESSED: begin
				if (!down || timer_sat > {1'b0, cfg.long_press_ms})
					timer_d = '0;
				else
					timer_d = timer_sat;
			end
			default: begin
				timer_d = timer_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			timer_q <= '0;
		end else if (advance) begin
			state_q <= state_d;
			timer_q <= timer_d;
		end
	end

	assign state = state_q;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q) && $stable(timer_q))
		else $error("key state moved without an item");

	a_press_edge: assert property (@(posedge clk) disable iff (!arst_n)
		advance && state_q == ST_PRESS_EDGE |=> state_q == ST_PRESSED || state_q == ST_IDLE)
		else $error("press edge held longer than one item");

	a_release_edge: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (state_q == ST_RELEASE_EDGE || state_q == ST_LONG_RELEASE_EDGE)
		|=> state_q == ST_IDLE)
		else $error("release edge did not return to idle");

	a_timer_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		advance && state_q == ST_IDLE && down |=> timer_q == '0)
		else $error("timer not cleared on debounce entry");

endmodule

/* design/key_debounce_long_press_top.sv */
// Output: an item's result is registered, shown the cycle after acceptance.
// Throughput: one item per cycle while result_ready is high; a new item is
// taken with the pending result; the single result register sets the rate.
// Reset: arst_n clears every key to idle with a zero timer, empties the
// result register and loads debounce 10 ms and long press 100 ms.
module key_debounce_long_press_top
	import kdlp_pkg::*;
#(
	parameter int NUM_KEYS = NUM_KEYS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  item_t                item,
	output logic                 result_valid,
	input  logic                 result_ready,
	output result_t              result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	cfg_t               cfg_q;
	logic               result_valid_q;
	logic [IN_KEYS-1:0] levels_q;
	logic               accept;
	logic [NUM_KEYS-1:0] down;
	key_state_t         st [NUM_KEYS];
	logic [2:0]         rep [IN_KEYS];
	logic [IN_KEYS-1:0] lvl_rep;

	assign item_ready = !result_valid_q || result_ready;
	assign accept     = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms   <= DEBOUNCE_RST;
			cfg_q.long_press_ms <= LONG_RST;
		end else if (cfg_we) begin
			if (cfg_index == CFG_DEBOUNCE)
				cfg_q.debounce_ms <= cfg_data;
			else if (cfg_index == CFG_LONG)
				cfg_q.long_press_ms <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			levels_q       <= '0;
		end else begin
			if (accept)
				result_valid_q <= 1'b1;
			else if (result_ready)
				result_valid_q <= 1'b0;
			if (accept)
				levels_q <= lvl_rep;
		end
	end

	// keys without an input pin read as released
	for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
		if (k < IN_KEYS) begin : g_pin
			assign down[k] = !item.key_levels[k];
		end else begin : g_nopin
			assign down[k] = 1'b0;
		end

		kdlp_key u_key (
			.clk        (clk),
			.arst_n     (arst_n),
			.advance    (accept),
			.down       (down[k]),
			.elapsed_ms (item.elapsed_ms),
			.cfg        (cfg_q),
			.state      (st[k])
		);
	end

	// the key state registers double as the result payload
	for (genvar i = 0; i < IN_KEYS; i++) begin : g_rep
		if (i < NUM_KEYS) begin : g_have
			assign rep[i]     = st[i];
			assign lvl_rep[i] = item.key_levels[i];
		end else begin : g_absent
			assign rep[i]     = 3'd0;
			assign lvl_rep[i] = 1'b0;
		end
	end

	assign result_valid           = result_valid_q;
	assign result.front_state     = rep[0];
	assign result.back_state      = rep[1];
	assign result.left_state      = rep[2];
	assign result.right_state     = rep[3];
	assign result.middle_state    = rep[4];
	assign result.extra_state     = rep[5];
	assign result.sampled_levels  = levels_q;

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> result_valid)
		else $error("accepted item produced no result");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |-> !item_ready)
		else $error("item taken over an unread result");

	a_levels: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> result.sampled_levels[0] == $past(item.key_levels[0]))
		else $error("sampled level does not match the item");

endmodule
